>>> design/gws_pkg.sv
// package for the grid word search block
// payload structs, register indexes and default sizes; no dependencies

package gws_pkg;

   localparam int NUM_WORDS = 5;
   localparam int CHAR_W = 8;
   localparam int WORD_W = 64;
   localparam int CSR_INDEX_W = 3;

   localparam int GRID_ROWS_DEF = 128;
   localparam int GRID_COLS_DEF = 256;
   localparam int WORD_CHARS_DEF = 8;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] REG_WORD_ZERO = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_WORD_ONE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_WORD_TWO = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_WORD_THREE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_WORD_FOUR = 3'd4;

   typedef logic [NUM_WORDS-1:0][WORD_W-1:0] words_type;

   typedef struct packed {
      logic command;
      logic [6:0] row;
      logic [7:0] col;
      logic [7:0] character;
   } req_type;

   typedef struct packed {
      logic [NUM_WORDS-1:0] row_matches;
      logic [NUM_WORDS-1:0] column_matches;
   } rsp_type;

endpackage

>>> design/gws_cmp.sv
// shared compare unit: checks one grid cell against character m of all words
// depends on gws_pkg

module gws_cmp #(
   parameter int WORD_CHARS = gws_pkg::WORD_CHARS_DEF,
   parameter int MW = 3
) (
   input  gws_pkg::words_type            words,
   input  logic [MW-1:0]                 char_pos,
   input  logic [gws_pkg::CHAR_W-1:0]    grid_char,
   input  logic                          cell_oob,
   output logic [gws_pkg::NUM_WORDS-1:0] hit,
   output logic [gws_pkg::NUM_WORDS-1:0] nonempty
);
   import gws_pkg::*;

   logic [CHAR_W-1:0] word_byte [NUM_WORDS][WORD_CHARS];
   // live[k][m]: characters 0..m of word k are all nonzero
   logic [WORD_CHARS-1:0] live [NUM_WORDS];

   always_comb begin
      for (int k = 0; k < NUM_WORDS; k++) begin
         for (int j = 0; j < WORD_CHARS; j++) begin
            word_byte[k][j] = words[k][CHAR_W*j +: CHAR_W];
         end
         live[k][0] = (word_byte[k][0] != '0);
         for (int j = 1; j < WORD_CHARS; j++) begin
            live[k][j] = live[k][j-1] && (word_byte[k][j] != '0);
         end
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_WORDS; k++) begin
         nonempty[k] = live[k][0];
         // past the end of the word nothing is checked
         hit[k] = !live[k][char_pos] || (!cell_oob && grid_char == word_byte[k][char_pos]);
      end
   end

endmodule

>>> design/grid_word_search.sv
// grid word search top level: grid memory, clearing pass and query sequencer
// depends on gws_pkg and gws_cmp
//
// Usage. Input items arrive on req_valid/req_ready with req_data (command, row,
// col, character). A write stores one byte into the grid, if in range, and gives
// no result. A query gives one result on rsp_valid/rsp_ready:
// row_matches (words reading along increasing column) and column_matches
// (words reading along increasing row).
// A query steps one grid memory read port through WORD_CHARS cells along the
// row, then WORD_CHARS along the column, one read a cycle, with the compare of
// each read in the cycle after it; the query then passes the drain and done
// states, and the result is registered as the block returns to idle, ready for
// the next item. The block holds one item at a time.
// The result sits in an output register: writes and new queries are taken
// while it waits; a query that finishes while the old result is still not
// taken waits for the receiver before it frees the input.
// After reset the block clears all GRID_ROWS*GRID_COLS grid memory entries
// (32768 by default) one entry a cycle, with req_ready low.
// The user is to write word registers on csr_valid/csr_ready only while the
// block is idle; it does not enforce this. Indexes past the fifth are ignored.

module grid_word_search #(
   parameter int GRID_ROWS = gws_pkg::GRID_ROWS_DEF,
   parameter int GRID_COLS = gws_pkg::GRID_COLS_DEF,
   parameter int WORD_CHARS = gws_pkg::WORD_CHARS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  gws_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output gws_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [gws_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gws_pkg::WORD_W-1:0]      csr_data
);
   import gws_pkg::*;

   localparam int DEPTH = GRID_ROWS * GRID_COLS;
   localparam int AW = $clog2(DEPTH);
   localparam int RW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
   localparam int CW = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
   localparam int RSUM_W = $clog2(128 + GRID_ROWS + WORD_CHARS);
   localparam int CSUM_W = $clog2(256 + GRID_COLS + WORD_CHARS);
   localparam int MW = (WORD_CHARS > 1) ? $clog2(WORD_CHARS) : 1;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_QUERY = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   words_type words_ff, words_in;
   logic [6:0] q_row_ff, q_row_in;
   logic [7:0] q_col_ff, q_col_in;
   logic [MW-1:0] m_ff, m_in;
   logic dir_ff, dir_in;
   logic rd_valid_ff, rd_valid_in;
   logic rd_oob_ff, rd_oob_in;
   logic rd_dir_ff, rd_dir_in;
   logic [MW-1:0] rd_m_ff, rd_m_in;
   logic [NUM_WORDS-1:0] along_col_ff, along_col_in;
   logic [NUM_WORDS-1:0] along_row_ff, along_row_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic [CHAR_W-1:0] grid_mem [DEPTH];
   logic [CHAR_W-1:0] mem_q_ff;

   logic req_xfer, rsp_free, last_step;
   logic [RSUM_W-1:0] a_row;
   logic [CSUM_W-1:0] a_col;
   logic a_inb;
   logic [AW-1:0] a_addr;
   logic wr_en;
   logic [AW-1:0] wr_addr;
   logic [CHAR_W-1:0] wr_data;
   logic [NUM_WORDS-1:0] hit, nonempty;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;
   assign last_step = dir_ff && (m_ff == MW'(WORD_CHARS - 1));

   // one address unit, shared by writes and query reads
   always_comb begin
      if (state_ff == ST_IDLE) begin
         a_row = RSUM_W'(req_data.row);
         a_col = CSUM_W'(req_data.col);
      end else begin
         a_row = RSUM_W'(q_row_ff) + (dir_ff ? RSUM_W'(m_ff) : '0);
         a_col = CSUM_W'(q_col_ff) + (dir_ff ? '0 : CSUM_W'(m_ff));
      end
      a_inb = (a_row < RSUM_W'(GRID_ROWS)) && (a_col < CSUM_W'(GRID_COLS));
      a_addr = AW'(a_row[RW-1:0] * GRID_COLS) + AW'(a_col[CW-1:0]);
   end

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         wr_en = 1'b1;
         wr_addr = clr_ff;
         wr_data = '0;
      end else begin
         wr_en = req_xfer && (req_data.command == CMD_WRITE) && a_inb;
         wr_addr = a_addr;
         wr_data = req_data.character;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_mem[wr_addr] <= wr_data;
      end
      mem_q_ff <= grid_mem[a_addr];
   end

   gws_cmp #(
      .WORD_CHARS(WORD_CHARS),
      .MW(MW)
   ) u_cmp (
      .words(words_ff),
      .char_pos(rd_m_ff),
      .grid_char(mem_q_ff),
      .cell_oob(rd_oob_ff),
      .hit(hit),
      .nonempty(nonempty)
   );

   always_comb begin
      words_in = words_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_WORD_ZERO: words_in[0] = csr_data;
            REG_WORD_ONE: words_in[1] = csr_data;
            REG_WORD_TWO: words_in[2] = csr_data;
            REG_WORD_THREE: words_in[3] = csr_data;
            REG_WORD_FOUR: words_in[4] = csr_data;
            default: words_in = words_ff;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      q_row_in = q_row_ff;
      q_col_in = q_col_ff;
      m_in = m_ff;
      dir_in = dir_ff;
      rd_valid_in = 1'b0;
      rd_oob_in = rd_oob_ff;
      rd_dir_in = rd_dir_ff;
      rd_m_in = rd_m_ff;
      along_col_in = along_col_ff;
      along_row_in = along_row_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;

      // compare trails the read, in the cycle after it
      if (rd_valid_ff) begin
         if (rd_dir_ff) begin
            along_row_in = along_row_ff & hit;
         end else begin
            along_col_in = along_col_ff & hit;
         end
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer && req_data.command == CMD_QUERY) begin
               q_row_in = req_data.row;
               q_col_in = req_data.col;
               m_in = '0;
               dir_in = 1'b0;
               along_col_in = nonempty;
               along_row_in = nonempty;
               state_in = ST_QUERY;
            end
         end
         ST_QUERY: begin
            rd_valid_in = 1'b1;
            rd_oob_in = !a_inb;
            rd_dir_in = dir_ff;
            rd_m_in = m_ff;
            if (m_ff == MW'(WORD_CHARS - 1)) begin
               m_in = '0;
               dir_in = 1'b1;
            end else begin
               m_in = m_ff + 1'b1;
            end
            if (last_step) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.row_matches = along_col_ff;
               rsp_data_in.column_matches = along_row_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         words_ff <= '0;
         m_ff <= '0;
         dir_ff <= 1'b0;
         rd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         words_ff <= words_in;
         m_ff <= m_in;
         dir_ff <= dir_in;
         rd_valid_ff <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_row_ff <= q_row_in;
      q_col_ff <= q_col_in;
      rd_oob_ff <= rd_oob_in;
      rd_dir_ff <= rd_dir_in;
      rd_m_ff <= rd_m_in;
      along_col_ff <= along_col_in;
      along_row_ff <= along_row_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   // no grid write from the input side while the clearing pass runs
   a_no_write_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (!req_ready && wr_addr == clr_ff))
      else $error("input taken during clearing pass");

   // a compare only follows a read issued by the query sequencer
   a_read_from_query: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> ($past(state_ff) == ST_QUERY))
      else $error("compare without a query read");

   // the drain cycle always carries the last column-direction compare
   a_drain_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (rd_valid_ff && rd_dir_ff))
      else $error("drain without the final compare");

   // a finished query always lands in the output register
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("query result lost");

   // clearing counter only moves during the clearing pass
   a_clear_still: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_CLEAR) |=> $stable(clr_ff))
      else $error("clear counter moved outside clearing pass");
`endif

endmodule

>>> dv/grid_word_search_tb.sv
// self-checking testbench for grid_word_search: grid writes, five-word queries, word registers
// depends on gws_pkg and the grid_word_search top level; holds its own grid and match predictor
`timescale 1ns / 100ps

module grid_word_search_tb;
   import gws_pkg::*;

   localparam int ROWS = GRID_ROWS_DEF;
   localparam int COLS = GRID_COLS_DEF;
   localparam int CHARS = WORD_CHARS_DEF;
   localparam int SETTLE_CYCLES = 2 * CHARS + 8;

   // predicts match masks from a private grid copy and the word registers
   class match_scoreboard;
      logic [7:0] cells [ROWS*COLS];
      logic [WORD_W-1:0] words [NUM_WORDS];
      rsp_type pending [$];
      int errors;
      int checked;
      int hits;

      function new();
         foreach (cells[i]) cells[i] = 8'h00;
         foreach (words[k]) words[k] = '0;
         errors = 0;
         checked = 0;
         hits = 0;
      endfunction

      function void set_word(int idx, logic [WORD_W-1:0] value);
         if (idx < NUM_WORDS) words[idx] = value;
      endfunction

      function int word_len(logic [WORD_W-1:0] w);
         int n;
         n = 0;
         while (n < CHARS && w[8*n +: 8] != 8'h00) n++;
         return n;
      endfunction

      function logic [7:0] cell_value(int r, int c);
         if (r >= ROWS || c >= COLS) return 8'h00;
         return cells[r*COLS + c];
      endfunction

      function bit word_reads_at(logic [WORD_W-1:0] w, int r, int c, int dr, int dc);
         int n;
         logic [7:0] got;
         n = word_len(w);
         if (n == 0) return 1'b0;
         for (int m = 0; m < n; m++) begin
            got = cell_value(r + m*dr, c + m*dc);
            if (got == 8'h00 || got != w[8*m +: 8]) return 1'b0;
         end
         return 1'b1;
      endfunction

      function rsp_type predict_query(int r, int c);
         rsp_type res;
         res = '0;
         if (r < ROWS && c < COLS) begin
            for (int k = 0; k < NUM_WORDS; k++) begin
               res.row_matches[k] = word_reads_at(words[k], r, c, 0, 1);
               res.column_matches[k] = word_reads_at(words[k], r, c, 1, 0);
            end
         end
         return res;
      endfunction

      function void note_item(req_type item);
         if (item.command == CMD_WRITE) begin
            if (item.row < ROWS && item.col < COLS)
               cells[item.row*COLS + item.col] = item.character;
         end else begin
            pending.push_back(predict_query(item.row, item.col));
         end
      endfunction

      task report_mismatch(string msg);
         $display("mismatch at %0t: %s", $time, msg);
         errors++;
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("result %b/%b with no query waiting",
                                      got.row_matches, got.column_matches));
         end else begin
            want = pending.pop_front();
            checked++;
            if (want != '0) hits++;
            if (got.row_matches !== want.row_matches)
               report_mismatch($sformatf("row_matches got %b want %b",
                                         got.row_matches, want.row_matches));
            if (got.column_matches !== want.column_matches)
               report_mismatch($sformatf("column_matches got %b want %b",
                                         got.column_matches, want.column_matches));
         end
      endtask
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [WORD_W-1:0] csr_data;

   match_scoreboard sb = new();
   int sent_count = 0;
   int query_count = 0;
   bit no_gaps = 1'b0;
   logic hold_rsp = 1'b0;

   grid_word_search DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result transfers
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_data);
   end

   // receiver: random stalls, quiet stretches, and one long hold-off
   initial begin
      int stall;
      rsp_ready = 1'b0;
      wait (!reset);
      forever begin
         stall = (((sb.checked / 40) % 4) == 2) ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         while (hold_rsp) begin
            rsp_ready <= 1'b0;
            @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // long receiver hold-off while the sender keeps offering
   initial begin
      wait (sent_count >= 280);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (400) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      #5_000_000;
      $display("grid_word_search verification failed");
      $finish;
   end

   task automatic offer_item(input req_type item);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      sb.note_item(item);
      sent_count++;
      if (item.command == CMD_QUERY) query_count++;
   endtask

   task automatic place_char(input int r, input int c, input logic [7:0] ch);
      req_type item;
      item.command = CMD_WRITE;
      item.row = r[6:0];
      item.col = c[7:0];
      item.character = ch;
      offer_item(item);
   endtask

   task automatic send_query(input int r, input int c);
      req_type item;
      item.command = CMD_QUERY;
      item.row = r[6:0];
      item.col = c[7:0];
      item.character = 8'($urandom);
      offer_item(item);
   endtask

   // lays a word into the grid, skipping cells past the edge, optionally spoiling one char
   task automatic place_word(input logic [WORD_W-1:0] w, input int r, input int c,
                             input bit down, input bit corrupt);
      int n;
      int bad;
      int rr;
      int cc;
      logic [7:0] ch;
      n = sb.word_len(w);
      if (n == 0) return;
      bad = corrupt ? int'($urandom_range(0, n - 1)) : -1;
      for (int m = 0; m < n; m++) begin
         rr = r + (down ? m : 0);
         cc = c + (down ? 0 : m);
         if (rr < ROWS && cc < COLS) begin
            ch = w[8*m +: 8];
            if (m == bad) ch = $urandom_range(0, 1) ? 8'h00 : (ch ^ 8'h01);
            place_char(rr, cc, ch);
         end
      end
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [WORD_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      sb.set_word(idx, value);
   endtask

   task automatic load_words(input logic [WORD_W-1:0] w0, input logic [WORD_W-1:0] w1,
                             input logic [WORD_W-1:0] w2, input logic [WORD_W-1:0] w3,
                             input logic [WORD_W-1:0] w4);
      write_reg(REG_WORD_ZERO, w0);
      write_reg(REG_WORD_ONE, w1);
      write_reg(REG_WORD_TWO, w2);
      write_reg(REG_WORD_THREE, w3);
      write_reg(REG_WORD_FOUR, w4);
      csr_valid <= 1'b0;
   endtask

   // stop offering, wait for every result, then let a write still in flight finish
   task automatic drain_block();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [WORD_W-1:0] pack_word(input string s);
      logic [WORD_W-1:0] w;
      w = '0;
      for (int i = 0; i < s.len() && i < CHARS; i++) w[8*i +: 8] = s[i];
      return w;
   endfunction

   // short words over a tiny alphabet so matches overlap; junk may follow the terminator
   function automatic logic [WORD_W-1:0] random_word(input int max_len);
      logic [WORD_W-1:0] w;
      int n;
      w = '0;
      n = $urandom_range(1, max_len);
      for (int i = 0; i < n; i++) w[8*i +: 8] = 8'h61 + 8'($urandom_range(0, 2));
      if (n < CHARS - 1 && $urandom_range(0, 1))
         for (int i = n + 1; i < CHARS; i++) w[8*i +: 8] = 8'($urandom);
      return w;
   endfunction

   task automatic run_random(input int target);
      int pick;
      int k;
      int r;
      int c;
      bit down;
      logic [WORD_W-1:0] w;
      logic [7:0] ch;
      while (sent_count < target) begin
         no_gaps = ((sent_count / 60) % 4) == 3;
         pick = $urandom_range(0, 9);
         if (pick <= 5) begin
            k = $urandom_range(0, NUM_WORDS - 1);
            w = sb.words[k];
            down = $urandom_range(0, 1);
            if ($urandom_range(0, 3) == 0) begin
               // near the far border so longer words run off the grid
               r = down ? $urandom_range(ROWS - CHARS, ROWS - 1) : $urandom_range(0, ROWS - 1);
               c = down ? $urandom_range(0, COLS - 1) : $urandom_range(COLS - CHARS, COLS - 1);
            end else begin
               r = $urandom_range(0, 15);
               c = $urandom_range(0, 15);
            end
            place_word(w, r, c, down, $urandom_range(0, 4) == 0);
            send_query(r, c);
            if ($urandom_range(0, 3) == 0 && r + down < ROWS && c + !down < COLS)
               send_query(r + down, c + !down);
         end else if (pick <= 7) begin
            r = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, ROWS - 1);
            c = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, COLS - 1);
            case ($urandom_range(0, 3))
               0: ch = 8'h00;
               1: ch = 8'hFF;
               2: ch = 8'($urandom);
               default: begin
                  w = sb.words[$urandom_range(0, NUM_WORDS - 1)];
                  ch = w[8*$urandom_range(0, CHARS - 1) +: 8];
               end
            endcase
            place_char(r, c, ch);
         end else begin
            r = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, ROWS - 1);
            c = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, COLS - 1);
            send_query(r, c);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      load_words(pack_word("Xanthos"), pack_word("Patara"), pack_word("Myra"),
                 pack_word("Arycanda"), pack_word("Phaselis"));

      // directed: word at the origin, at the corner, off the edge, cleared cell, 0xff cell
      place_word(sb.words[2], 0, 0, 1'b0, 1'b0);
      send_query(0, 0);
      place_word(sb.words[2], ROWS - 4, COLS - 1, 1'b1, 1'b0);
      send_query(ROWS - 4, COLS - 1);
      send_query(ROWS - 1, COLS - 1);
      place_word(sb.words[1], ROWS - 1, COLS - 4, 1'b0, 1'b0);
      send_query(ROWS - 1, COLS - 4);
      place_char(0, 1, 8'h00);
      send_query(0, 0);
      place_char(0, 1, "y");
      send_query(0, 0);
      place_char(64, 128, 8'hFF);
      send_query(64, 128);
      send_query(10, 200);
      run_random(200);

      // extremes: all-ones word, empty word, one-char word, junk after terminator
      drain_block();
      for (int i = NUM_WORDS; i < (1 << CSR_INDEX_W); i++)
         write_reg(CSR_INDEX_W'(i), {$urandom, $urandom});
      load_words({WORD_W{1'b1}}, '0, 64'h0000_0000_0000_0001, 64'h5A5A_5A5A_5A00_6362,
                 {$urandom, $urandom});
      run_random(360);

      drain_block();
      load_words(random_word(3), random_word(3), random_word(2), random_word(4),
                 random_word(1));
      run_random(430);
      // sender waits for every result before going on
      drain_block();
      run_random(500);

      drain_block();
      load_words(pack_word("Phaselis"), random_word(8), random_word(8), random_word(5),
                 random_word(8));
      run_random(650);

      drain_block();
      $display("run covered %0d items, %0d queries, %0d results checked (%0d with a match)",
               sent_count, query_count, sb.checked, sb.hits);
      $display("four word settings including all-ones and empty words, one long receiver stall");
      if (sb.errors == 0) begin
         $display("grid_word_search verification clean");
      end else begin
         $display("grid_word_search verification failed");
      end
      $finish;
   end

endmodule
